>>> sv/rpct_pkg.sv
// Package for the refcounted page cache table.
// Request modes, result codes and controller/datapath command types.
package rpct_pkg;

  typedef enum logic [1:0] {
    MODE_LOOKUP  = 2'd0,
    MODE_INSERT  = 2'd1,
    MODE_ADDREF  = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_ADOPTED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic load;
    logic rd;
    logic cmp;
    logic step;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic hit_now;
    logic last;
  } stat_t;

endpackage

>>> sv/refcounted_page_cache_table.sv
// Top level of the refcounted page cache table.
// Depends on rpct_pkg, rpct_ctrl and rpct_datapath.
//
//  channel  dir  tdata                               tuser
//  s_axis   in   mount, file, page, frame (136 b)    mode
//  m_axis   out  result_frame, live_entries (32 b)   status, release_frame
//
// One request at a time. A request scans the entry memory one entry at a
// time, in a read state and then a compare state, until the first match or
// the last entry; an update state then updates the entry and the result.
// Reset clears the valid bits and the live count at once; no clearing pass.
// A result waits in the output register; the next transfer is taken in the
// cycle the result leaves.
module refcounted_page_cache_table #(
  parameter int ENTRIES  = 64,
  parameter int REF_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mount_token[31:0], file_ident[63:32], page_index[115:64], page_frame[135:116]
  input  logic [135:0] s_axis_tdata,
  // mode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_frame[19:0], live_entries[26:20], zero fill
  output logic [31:0]  m_axis_tdata,
  // status[1:0], release_frame[2]
  output logic [2:0]   m_axis_tuser
);

  rpct_pkg::cmd_t  cmd;
  rpct_pkg::stat_t st;
  logic [1:0]  status;
  logic [19:0] frame;
  logic        rel;
  logic [6:0]  live;

  rpct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  rpct_datapath #(
    .ENTRIES  (ENTRIES),
    .REF_BITS (REF_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_mode     (s_axis_tuser),
    .in_mount    (s_axis_tdata[31:0]),
    .in_file     (s_axis_tdata[63:32]),
    .in_page     (s_axis_tdata[115:64]),
    .in_frame    (s_axis_tdata[135:116]),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_status  (status),
    .out_frame   (frame),
    .out_release (rel),
    .out_live    (live)
  );

  assign m_axis_tdata = {5'd0, live, frame};
  assign m_axis_tuser = {rel, status};

endmodule

>>> sv/rpct_ctrl.sv
// Controller state machine of the refcounted page cache table.
// Depends on rpct_pkg; drives rpct_datapath through cmd_t.
module rpct_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  input  rpct_pkg::stat_t st,
  output rpct_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !st.out_busy || out_ready;
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (st.hit_now || st.last) begin
          state_next = S_UPD;
        end else begin
          cmd.step = 1'b1;
          state_next = S_RD;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/rpct_datapath.sv
// Datapath of the refcounted page cache table: entry memory, valid bits,
// scan registers and output register. Depends on rpct_pkg.
module rpct_datapath #(
  parameter int ENTRIES  = 64,
  parameter int REF_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  rpct_pkg::cmd_t  cmd,
  output rpct_pkg::stat_t st,
  input  logic [1:0]      in_mode,
  input  logic [31:0]     in_mount,
  input  logic [31:0]     in_file,
  input  logic [51:0]     in_page,
  input  logic [19:0]     in_frame,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [1:0]      out_status,
  output logic [19:0]     out_frame,
  output logic            out_release,
  output logic [6:0]      out_live
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int KW = 116;
  localparam int DW = KW + 20 + REF_BITS;
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  logic [DW-1:0] mem [ENTRIES];
  logic [DW-1:0] rd;
  logic [ENTRIES-1:0] valid;
  logic [CW-1:0] total;

  logic [1:0]  r_mode;
  logic [KW-1:0] r_key;
  logic [19:0] r_frame;
  logic [IW-1:0] idx, hit_idx, free_idx;
  logic hit, free_found;

  logic [KW-1:0] rd_key;
  logic [19:0] rd_frame;
  logic [REF_BITS-1:0] rd_refs, refs_inc;
  logic match;

  logic wr_en;
  logic [IW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  assign rd_key   = rd[DW-1 -: KW];
  assign rd_frame = rd[REF_BITS +: 20];
  assign rd_refs  = rd[REF_BITS-1:0];
  assign refs_inc = (rd_refs == REF_MAX) ? rd_refs : rd_refs + 1'b1;

  always_comb begin
    if (r_mode[1]) begin
      match = (rd_frame == r_frame);
    end else begin
      match = (rd_key == r_key);
    end
  end

  assign st.hit_now  = valid[idx] && match;
  assign st.last     = (idx == IW'(ENTRIES - 1));
  assign st.out_busy = out_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_mode  <= in_mode;
      r_key   <= {in_mount, in_file, in_page};
      r_frame <= in_frame;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = {rd_key, rd_frame, refs_inc};
    if (cmd.upd) begin
      if (hit) begin
        if (r_mode == rpct_pkg::MODE_RELEASE) begin
          wr_en   = (rd_refs > REF_BITS'(1));
          wr_data = {rd_key, rd_frame, rd_refs - 1'b1};
        end else begin
          wr_en = 1'b1;
        end
      end else if (r_mode == rpct_pkg::MODE_INSERT && free_found) begin
        wr_en   = 1'b1;
        wr_addr = free_idx;
        wr_data = {r_key, r_frame, REF_BITS'(1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      total      <= '0;
      out_valid  <= 1'b0;
      idx        <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        idx        <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end
      if (cmd.cmp) begin
        if (st.hit_now) begin
          hit     <= 1'b1;
          hit_idx <= idx;
        end
        if (!valid[idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
      end
      if (cmd.step) begin
        idx <= idx + 1'b1;
      end
      if (cmd.upd) begin
        out_valid   <= 1'b1;
        out_status  <= rpct_pkg::ST_MISS;
        out_frame   <= '0;
        out_release <= 1'b0;
        out_live    <= 7'(total);
        if (hit) begin
          out_status <= (r_mode == rpct_pkg::MODE_INSERT) ? rpct_pkg::ST_ADOPTED
                                                          : rpct_pkg::ST_OK;
          out_frame  <= rd_frame;
          if (r_mode == rpct_pkg::MODE_RELEASE && rd_refs <= REF_BITS'(1)) begin
            valid[hit_idx] <= 1'b0;
            out_release    <= 1'b1;
            if (total != '0) begin
              total    <= total - 1'b1;
              out_live <= 7'(total - 1'b1);
            end
          end
        end else if (r_mode == rpct_pkg::MODE_INSERT) begin
          if (free_found) begin
            valid[free_idx] <= 1'b1;
            total      <= total + 1'b1;
            out_live   <= 7'(total + 1'b1);
            out_status <= rpct_pkg::ST_OK;
            out_frame  <= r_frame;
          end else begin
            out_status <= rpct_pkg::ST_FULL;
          end
        end
      end
    end
  end

endmodule
